>>> hdl/itp_pkg.sv
// ----------------------------------------------------------------------------
// itp_pkg
// shared types, character constants and operator helpers of the infix to
// postfix converter
// ----------------------------------------------------------------------------
package itp_pkg;

	typedef logic [2:0] op_code_t;
	typedef logic [1:0] act_kind_t;
	typedef logic [1:0] err_code_t;

	// operator stack codes
	localparam op_code_t OP_OPEN = 3'd0;
	localparam op_code_t OP_ADD  = 3'd1;
	localparam op_code_t OP_SUB  = 3'd2;
	localparam op_code_t OP_MUL  = 3'd3;
	localparam op_code_t OP_DIV  = 3'd4;

	// what the stack does for an item
	localparam act_kind_t ACT_NONE  = 2'd0;
	localparam act_kind_t ACT_OPEN  = 2'd1;
	localparam act_kind_t ACT_CLOSE = 2'd2;
	localparam act_kind_t ACT_OP    = 2'd3;

	// result error codes
	localparam err_code_t ERR_NONE      = 2'd0;
	localparam err_code_t ERR_FULL      = 2'd1;
	localparam err_code_t ERR_UNMATCHED = 2'd2;

	localparam logic [7:0] CH_ADD   = 8'h2B;
	localparam logic [7:0] CH_SUB   = 8'h2D;
	localparam logic [7:0] CH_MUL   = 8'h2A;
	localparam logic [7:0] CH_DIV   = 8'h2F;
	localparam logic [7:0] CH_OPEN  = 8'h28;
	localparam logic [7:0] CH_CLOSE = 8'h29;
	localparam logic [7:0] CH_US    = 8'h5F;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_UC_A  = 8'h41;
	localparam logic [7:0] CH_UC_Z  = 8'h5A;
	localparam logic [7:0] CH_LC_A  = 8'h61;
	localparam logic [7:0] CH_LC_Z  = 8'h7A;
	localparam logic [7:0] CH_NULL  = 8'h00;

	// sequencer to output stage
	typedef struct packed {
		logic      start;     // new item accepted
		logic      emit;      // ch is one more postfix character
		logic [7:0] ch;
		logic      fin;       // item finished, close its results
		logic      end_expr;
		err_code_t err;
	} emit_t;

	function automatic logic is_alnum(input logic [7:0] c);
		return (c >= CH_ZERO && c <= CH_NINE) || (c >= CH_UC_A && c <= CH_UC_Z) ||
			(c >= CH_LC_A && c <= CH_LC_Z);
	endfunction

	function automatic logic [7:0] code_char(input op_code_t code);
		logic [7:0] c;
		unique case (code)
			OP_ADD:  c = CH_ADD;
			OP_SUB:  c = CH_SUB;
			OP_MUL:  c = CH_MUL;
			OP_DIV:  c = CH_DIV;
			default: c = CH_OPEN;
		endcase
		return c;
	endfunction

	function automatic logic [1:0] op_rank(input op_code_t code);
		logic [1:0] r;
		unique case (code)
			OP_ADD, OP_SUB: r = 2'd1;
			OP_MUL, OP_DIV: r = 2'd2;
			default:        r = 2'd0;
		endcase
		return r;
	endfunction

	function automatic op_code_t char_code(input logic [7:0] c);
		op_code_t code;
		unique case (c)
			CH_ADD:  code = OP_ADD;
			CH_SUB:  code = OP_SUB;
			CH_MUL:  code = OP_MUL;
			CH_DIV:  code = OP_DIV;
			default: code = OP_OPEN;
		endcase
		return code;
	endfunction

endpackage

>>> hdl/itp_if.sv
// ----------------------------------------------------------------------------
// itp_if
// valid/ready channels of the converter: infix characters in, postfix out
// ----------------------------------------------------------------------------
interface itp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_char;
	logic       end_of_expression;

	modport source (output valid, output in_char, output end_of_expression, input ready);
	modport sink   (input valid, input in_char, input end_of_expression, output ready);
endinterface

interface itp_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_char;
	logic       char_valid;
	logic       run_last;
	logic       expr_done;
	logic [1:0] error_code;

	modport source (output valid, output out_char, output char_valid, output run_last,
		output expr_done, output error_code, input ready);
	modport sink   (input valid, input out_char, input char_valid, input run_last,
		input expr_done, input error_code, output ready);
endinterface

>>> hdl/itp_ram.sv
// ----------------------------------------------------------------------------
// itp_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module itp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> hdl/itp_out_stage.sv
// ----------------------------------------------------------------------------
// itp_out_stage
// one-character lookahead and output register; marks the last result of an
// item and caps the result count
// ----------------------------------------------------------------------------
module itp_out_stage import itp_pkg::*; #(
	parameter int STACK_DEPTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  emit_t             emit,
	output logic              adv,
	itp_out_if.source         postfix
);

	localparam int MAX_RES = 2 * STACK_DEPTH + 1;
	localparam int GW      = $clog2(MAX_RES + 1);

	logic          valid_q;
	logic          pend_v_q;
	logic [7:0]    pend_q;
	logic [GW-1:0] gen_q;

	logic          take_char;
	logic          load;
	logic [7:0]    ld_char;
	logic          ld_cv;
	logic          ld_last;
	logic          ld_done;

	logic [7:0]    out_char_q;
	logic          char_valid_q;
	logic          run_last_q;
	logic          expr_done_q;
	err_code_t     error_code_q;

	assign adv       = !valid_q || postfix.ready;
	assign take_char = emit.emit && (gen_q < GW'(MAX_RES));

	always_comb begin
		load    = 1'b0;
		ld_char = pend_q;
		ld_cv   = 1'b1;
		ld_last = 1'b0;
		ld_done = 1'b0;
		if (take_char && pend_v_q) begin
			load = 1'b1;
		end else if (emit.fin) begin
			if (pend_v_q) begin
				load    = 1'b1;
				ld_last = 1'b1;
				ld_done = emit.end_expr;
			end else if (emit.err != ERR_NONE || emit.end_expr) begin
				// marker result, nothing written for this item
				load    = 1'b1;
				ld_char = CH_NULL;
				ld_cv   = 1'b0;
				ld_last = 1'b1;
				ld_done = emit.end_expr;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= 1'b0;
			pend_v_q <= 1'b0;
			gen_q    <= '0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
			end else if (postfix.ready) begin
				valid_q <= 1'b0;
			end
			if (take_char) begin
				pend_v_q <= 1'b1;
				gen_q    <= gen_q + GW'(1);
			end else if (emit.fin) begin
				pend_v_q <= 1'b0;
			end
			if (emit.start) begin
				gen_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_char) begin
			pend_q <= emit.ch;
		end
		if (load) begin
			out_char_q   <= ld_char;
			char_valid_q <= ld_cv;
			run_last_q   <= ld_last;
			expr_done_q  <= ld_done;
			error_code_q <= emit.err;
		end
	end

	assign postfix.valid      = valid_q;
	assign postfix.out_char   = out_char_q;
	assign postfix.char_valid = char_valid_q;
	assign postfix.run_last   = run_last_q;
	assign postfix.expr_done  = expr_done_q;
	assign postfix.error_code = error_code_q;

endmodule

>>> hdl/itp_seq.sv
// ----------------------------------------------------------------------------
// itp_seq
// per-item sequencer: operand handling, operator stack push, pop and flush
// against the stack ram, top of stack cached in a register
// ----------------------------------------------------------------------------
module itp_seq import itp_pkg::*; #(
	parameter int STACK_DEPTH = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	itp_in_if.sink                 expr,
	input  logic                   adv,
	output emit_t                  emit,
	output logic                   ram_we,
	output logic [$clog2(STACK_DEPTH)-1:0] ram_waddr,
	output op_code_t               ram_wdata,
	output logic                   ram_re,
	output logic [$clog2(STACK_DEPTH)-1:0] ram_raddr,
	input  op_code_t               ram_rdata
);

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_LEAD  = 4'd1;
	localparam logic [3:0] ST_SPACE = 4'd2;
	localparam logic [3:0] ST_ACT   = 4'd3;
	localparam logic [3:0] ST_POPC  = 4'd4;
	localparam logic [3:0] ST_POPS  = 4'd5;
	localparam logic [3:0] ST_REFR  = 4'd6;
	localparam logic [3:0] ST_END   = 4'd7;
	localparam logic [3:0] ST_FIN   = 4'd8;

	logic [3:0]    state_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] paren_q;
	op_code_t      top_q;
	logic          in_operand_q;
	logic          unary_q;
	logic          end_q;
	act_kind_t     kind_q;
	op_code_t      code_q;
	err_code_t     err_q;
	logic [7:0]    lead_q;
	logic          zero_q;
	logic          handled_q;
	logic          endsp_q;
	logic          flush_q;

	logic          accept;
	logic [7:0]    c;
	logic          d_handled;
	logic          d_closes;
	logic          d_zero;
	act_kind_t     d_kind;
	op_code_t      d_code;
	err_code_t     d_err;
	logic [7:0]    d_lead;
	logic          full;
	logic          pop_go;
	logic          push_go;
	logic          drop_go;
	logic [CW-1:0] rd_idx;

	assign full   = (count_q == CW'(STACK_DEPTH));
	assign rd_idx = count_q - CW'(2);
	assign expr.ready = (state_q == ST_IDLE) || (state_q == ST_FIN && adv);
	assign accept = expr.valid && expr.ready;

	// decode of the incoming character against the current state
	always_comb begin
		c         = expr.in_char;
		d_handled = in_operand_q ? (is_alnum(c) || c == CH_US) : is_alnum(c);
		d_closes  = in_operand_q && !d_handled;
		d_zero    = !d_handled && c == CH_SUB && unary_q;
		d_code    = char_code(c);
		d_kind    = ACT_NONE;
		if (!d_handled) begin
			priority if (c == CH_OPEN) begin
				d_kind = ACT_OPEN;
			end else if (c == CH_CLOSE) begin
				d_kind = ACT_CLOSE;
			end else if (c == CH_ADD || c == CH_SUB || c == CH_MUL || c == CH_DIV) begin
				d_kind = ACT_OP;
			end else begin
				d_kind = ACT_NONE;
			end
		end
		d_err = ERR_NONE;
		unique case (d_kind)
			ACT_OPEN:  d_err = full ? ERR_FULL : ERR_NONE;
			ACT_CLOSE: d_err = (paren_q == '0) ? ERR_UNMATCHED : ERR_NONE;
			// a full stack only takes the push if at least one pop comes first
			ACT_OP:    d_err = (full && op_rank(top_q) < op_rank(d_code)) ? ERR_FULL : ERR_NONE;
			default:   d_err = ERR_NONE;
		endcase
		priority if (d_handled) begin
			d_lead = c;
		end else if (d_closes) begin
			d_lead = CH_SPACE;
		end else begin
			d_lead = CH_ZERO;
		end
	end

	always_comb begin
		pop_go = (count_q != '0) && ((kind_q == ACT_CLOSE) ? (top_q != OP_OPEN) :
			(kind_q == ACT_OP && op_rank(top_q) >= op_rank(code_q)));
		push_go = !pop_go && (kind_q == ACT_OPEN || kind_q == ACT_OP) && !full;
		drop_go = !pop_go && kind_q == ACT_CLOSE && count_q != '0;
	end

	always_comb begin
		emit          = '0;
		emit.start    = accept;
		emit.err      = err_q;
		emit.end_expr = end_q;
		emit.ch       = CH_SPACE;
		ram_we        = 1'b0;
		ram_waddr     = count_q[AW-1:0];
		ram_wdata     = code_q;
		ram_re        = 1'b0;
		ram_raddr     = rd_idx[AW-1:0];
		unique case (state_q)
			ST_LEAD: begin
				emit.emit = adv;
				emit.ch   = lead_q;
			end
			ST_SPACE: begin
				emit.emit = adv;
			end
			ST_ACT: begin
				ram_we = (state_q == ST_ACT) && push_go;
				ram_re = drop_go && count_q > CW'(1);
			end
			ST_POPC: begin
				emit.emit = adv;
				emit.ch   = code_char(top_q);
				ram_re    = adv && count_q > CW'(1);
			end
			ST_POPS: begin
				emit.emit = adv;
			end
			ST_END: begin
				emit.emit = adv && endsp_q;
			end
			ST_FIN: begin
				emit.fin = adv;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			count_q      <= '0;
			paren_q      <= '0;
			in_operand_q <= 1'b0;
			unary_q      <= 1'b1;
			flush_q      <= 1'b0;
		end else if (accept) begin
			in_operand_q <= d_handled && !expr.end_of_expression;
			unary_q      <= (c == CH_OPEN) || expr.end_of_expression;
			flush_q      <= 1'b0;
			state_q      <= (d_handled || d_closes || d_zero) ? ST_LEAD : ST_ACT;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
				end
				ST_LEAD: begin
					if (adv) begin
						priority if (zero_q) begin
							state_q <= ST_SPACE;
						end else if (handled_q) begin
							state_q <= end_q ? ST_END : ST_FIN;
						end else begin
							state_q <= ST_ACT;
						end
					end
				end
				ST_SPACE: begin
					if (adv) begin
						state_q <= ST_ACT;
					end
				end
				ST_ACT: begin
					priority if (pop_go) begin
						state_q <= ST_POPC;
					end else if (push_go) begin
						count_q <= count_q + CW'(1);
						if (code_q == OP_OPEN) begin
							paren_q <= paren_q + CW'(1);
						end
						state_q <= end_q ? ST_END : ST_FIN;
					end else if (drop_go) begin
						// matching open paren leaves the stack unwritten
						count_q <= count_q - CW'(1);
						paren_q <= paren_q - CW'(1);
						state_q <= ST_REFR;
					end else begin
						state_q <= end_q ? ST_END : ST_FIN;
					end
				end
				ST_POPC: begin
					if (adv) begin
						count_q <= count_q - CW'(1);
						if (top_q == OP_OPEN) begin
							paren_q <= paren_q - CW'(1);
						end
						state_q <= ST_POPS;
					end
				end
				ST_POPS: begin
					if (adv) begin
						priority if (!flush_q) begin
							state_q <= ST_ACT;
						end else if (count_q != '0) begin
							state_q <= ST_POPC;
						end else begin
							state_q <= ST_FIN;
						end
					end
				end
				ST_REFR: begin
					state_q <= end_q ? ST_END : ST_FIN;
				end
				ST_END: begin
					if (adv) begin
						flush_q <= 1'b1;
						state_q <= (count_q != '0) ? ST_POPC : ST_FIN;
					end
				end
				ST_FIN: begin
					if (adv) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// item context and cached top of stack
	always_ff @(posedge clk) begin
		if (accept) begin
			end_q     <= expr.end_of_expression;
			kind_q    <= d_kind;
			code_q    <= d_code;
			err_q     <= d_err;
			lead_q    <= d_lead;
			zero_q    <= d_zero;
			handled_q <= d_handled;
			endsp_q   <= d_handled && expr.end_of_expression;
		end
		if (ram_we) begin
			top_q <= code_q;
		end else if ((state_q == ST_POPS && adv) || state_q == ST_REFR) begin
			top_q <= ram_rdata;
		end
	end

endmodule

>>> hdl/infix_to_postfix_converter.sv
// ----------------------------------------------------------------------------
// infix_to_postfix_converter
// shunting-yard conversion of infix characters to postfix characters with an
// operator stack held in a synchronous ram
// ----------------------------------------------------------------------------
//
// channel   role    items                 payload
// expr      sink    infix characters      in_char, end_of_expression
// postfix   source  postfix characters    out_char, char_valid, run_last,
//                                         expr_done, error_code
//
// an end of expression flushes every stack entry; the stack ram read for the
// next top of stack hides under the two characters written per pop
// reset clears the stack count and the operand flag and sets the unary flag;
// the stack ram itself is not cleared, only entries below the count are ever read
// a stalled postfix side holds the sequencer; one result waits in the output
// register while the next is prepared in the lookahead register
//
module infix_to_postfix_converter import itp_pkg::*; #(
	parameter int STACK_DEPTH = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	itp_in_if.sink     expr,
	itp_out_if.source  postfix
);

	localparam int AW = $clog2(STACK_DEPTH);

	emit_t          emit;
	logic           adv;
	logic           ram_we;
	logic [AW-1:0]  ram_waddr;
	op_code_t       ram_wdata;
	logic           ram_re;
	logic [AW-1:0]  ram_raddr;
	op_code_t       ram_rdata;

	// control: decode, push, pop walk and flush
	itp_seq #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.expr      (expr),
		.adv       (adv),
		.emit      (emit),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	// operator stack, one 3-bit code per entry
	itp_ram #(
		.WIDTH ($bits(op_code_t)),
		.DEPTH (STACK_DEPTH)
	) u_stack (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// lookahead for the last-result mark, output register
	itp_out_stage #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.emit    (emit),
		.adv     (adv),
		.postfix (postfix)
	);

endmodule

>>> hdl/itp_checker.sv
// ----------------------------------------------------------------------------
// itp_checker
// port level checks of the converter, bound to the top level
// ----------------------------------------------------------------------------
module itp_checker import itp_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       expr_valid,
	input logic       expr_ready,
	input logic       postfix_valid,
	input logic       postfix_ready,
	input logic [7:0] postfix_out_char,
	input logic       postfix_char_valid,
	input logic       postfix_run_last,
	input logic       postfix_expr_done,
	input logic [1:0] postfix_error_code
);

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		postfix_valid && !postfix_ready |=> postfix_valid && $stable(postfix_out_char) &&
		$stable(postfix_char_valid) && $stable(postfix_run_last) &&
		$stable(postfix_error_code))
	else $error("stalled result changed");

	// one item at a time: no accept right after an accept
	assert property (@(posedge clk) disable iff (!arst_n)
		expr_valid && expr_ready |=> !expr_ready)
	else $error("input ready right after accept");

	// end of expression only on the last result of an item
	assert property (@(posedge clk) disable iff (!arst_n)
		postfix_valid && postfix_expr_done |-> postfix_run_last)
	else $error("expr_done without run_last");

	// marker result carries no character and closes the item
	assert property (@(posedge clk) disable iff (!arst_n)
		postfix_valid && !postfix_char_valid |-> postfix_run_last &&
		postfix_out_char == CH_NULL &&
		(postfix_expr_done || postfix_error_code != ERR_NONE))
	else $error("bad marker result");

	assert property (@(posedge clk) disable iff (!arst_n)
		postfix_valid |-> postfix_error_code == ERR_NONE ||
		postfix_error_code == ERR_FULL || postfix_error_code == ERR_UNMATCHED)
	else $error("unknown error code");

endmodule

bind infix_to_postfix_converter itp_checker u_itp_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.expr_valid         (expr.valid),
	.expr_ready         (expr.ready),
	.postfix_valid      (postfix.valid),
	.postfix_ready      (postfix.ready),
	.postfix_out_char   (postfix.out_char),
	.postfix_char_valid (postfix.char_valid),
	.postfix_run_last   (postfix.run_last),
	.postfix_expr_done  (postfix.expr_done),
	.postfix_error_code (postfix.error_code)
);

>>> verif/infix_to_postfix_converter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_tb
// feeds infix text into the converter, with directed expressions first and
// then random formulas, deep nests, broken text and raw bytes, and compares
// every postfix item with a shunting-yard predictor kept in step with the
// accepted input
// ----------------------------------------------------------------------------
module infix_to_postfix_converter_tb;
	import itp_pkg::*;

	localparam int STACK_DEPTH = 16;
	localparam int MAX_RESULTS = 2 * STACK_DEPTH + 1;
	localparam int IDLE_LIMIT  = 3000;     // cycles with no item moving on either side
	localparam int HOLD_CYCLES = 400;      // one long output stall to back up the input
	localparam int HOLD_AT     = 150;      // input items accepted before that stall
	localparam int DRAIN_WAIT  = 200;      // quiet cycles after the last expected item

	typedef struct packed {
		logic [7:0] ch;
		logic       eoe;
	} infix_item_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       ch_valid;
		logic       run_last;
		logic       done;
		err_code_t  err;
	} postfix_item_t;

	logic clk;
	logic arst_n;

	itp_in_if  expr ();
	itp_out_if postfix ();

	infix_to_postfix_converter #(
		.STACK_DEPTH(STACK_DEPTH)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.expr   (expr),
		.postfix(postfix)
	);

	// infix text waiting to be sent and postfix items the converter owes us
	infix_item_t   infix_q [$];
	postfix_item_t postfix_exp_q [$];

	// predictor state: operator stack, operand and unary-minus flags
	op_code_t   op_stk [STACK_DEPTH];
	int         stk_cnt;
	logic       in_word;
	logic       unary_ok;
	logic [7:0] postfix_text [$];

	int err_count;
	int in_count;
	int idle_cycles;

	// handshakes seen at the last rising edge
	logic in_took;
	logic out_took;

	// sender side
	int          tx_wait;
	logic        tx_burst;
	logic        tx_valid;
	infix_item_t tx_item;

	// receiver side
	int   rx_wait;
	logic rx_burst;
	logic rx_ready;
	int   hold_left;
	logic hold_done;

	postfix_item_t got_item;
	postfix_item_t exp_item;

	always #6 clk = ~clk;

	function automatic int pick_gap(input logic burst);
		return burst ? 0 : $urandom_range(0, 11);
	endfunction

	task automatic flag_error(input string msg);
		err_count++;
		$display("mismatch at %0t: %s", $realtime, msg);
	endtask

	// ------------------------------------------------------------------------
	// shunting-yard predictor
	// ------------------------------------------------------------------------

	function automatic logic word_char(input logic [7:0] c);
		return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
	endfunction

	function automatic int op_weight(input op_code_t code);
		case (code)
			OP_ADD, OP_SUB: return 1;
			OP_MUL, OP_DIV: return 2;
			default:        return 0;
		endcase
	endfunction

	function automatic logic [7:0] op_symbol(input op_code_t code);
		case (code)
			OP_ADD:  return CH_ADD;
			OP_SUB:  return CH_SUB;
			OP_MUL:  return CH_MUL;
			OP_DIV:  return CH_DIV;
			default: return CH_OPEN;
		endcase
	endfunction

	// characters beyond the per-item limit are dropped
	function automatic void put_char(input logic [7:0] c);
		if (postfix_text.size() < MAX_RESULTS)
			postfix_text = {postfix_text, c};
	endfunction

	function automatic void pop_op();
		stk_cnt--;
		put_char(op_symbol(op_stk[stk_cnt]));
		put_char(CH_SPACE);
	endfunction

	function automatic err_code_t push_op(input op_code_t code);
		if (stk_cnt < STACK_DEPTH) begin
			op_stk[stk_cnt] = code;
			stk_cnt++;
			return ERR_NONE;
		end
		// full stack drops the push
		return ERR_FULL;
	endfunction

	task automatic predict_postfix(input logic [7:0] c, input logic eoe);
		err_code_t     err;
		logic          taken;
		op_code_t      code;
		postfix_item_t item;
		int            k;
		err = ERR_NONE;
		taken = 1'b0;
		code = OP_OPEN;
		postfix_text.delete();

		// operands: a letter or digit opens one, underscores may follow
		if (in_word) begin
			if (word_char(c) || c == CH_US) begin
				put_char(c);
				taken = 1'b1;
			end else begin
				put_char(CH_SPACE);
				in_word = 1'b0;
			end
		end else if (word_char(c)) begin
			put_char(c);
			in_word = 1'b1;
			taken = 1'b1;
		end

		if (!taken) begin
			case (c)
				CH_OPEN: err = push_op(OP_OPEN);
				CH_CLOSE: begin
					while (stk_cnt > 0 && op_stk[stk_cnt - 1] != OP_OPEN)
						pop_op();
					// no open paren left means the close had no partner
					if (stk_cnt > 0)
						stk_cnt--;
					else
						err = ERR_UNMATCHED;
				end
				CH_ADD, CH_SUB, CH_MUL, CH_DIV: begin
					case (c)
						CH_ADD:  code = OP_ADD;
						CH_SUB:  code = OP_SUB;
						CH_MUL:  code = OP_MUL;
						default: code = OP_DIV;
					endcase
					// leading minus becomes a subtraction from zero
					if (c == CH_SUB && unary_ok) begin
						put_char(CH_ZERO);
						put_char(CH_SPACE);
					end
					while (stk_cnt > 0 && op_weight(op_stk[stk_cnt - 1]) >= op_weight(code))
						pop_op();
					err = push_op(code);
				end
				default: ;
			endcase
		end

		unary_ok = (c == CH_OPEN);

		// end of expression flushes everything, stray opens included
		if (eoe) begin
			if (in_word)
				put_char(CH_SPACE);
			in_word = 1'b0;
			while (stk_cnt > 0)
				pop_op();
			unary_ok = 1'b1;
		end

		if (postfix_text.size() == 0) begin
			// silent item: a marker only for an error or the end
			if (err != ERR_NONE || eoe) begin
				item.ch = CH_NULL;
				item.ch_valid = 1'b0;
				item.run_last = 1'b1;
				item.done = eoe;
				item.err = err;
				postfix_exp_q = {postfix_exp_q, item};
			end
		end else begin
			for (k = 0; k < postfix_text.size(); k++) begin
				item.ch = postfix_text[k];
				item.ch_valid = 1'b1;
				item.run_last = (k == postfix_text.size() - 1);
				item.done = item.run_last && eoe;
				item.err = err;
				postfix_exp_q = {postfix_exp_q, item};
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// stimulus text
	// ------------------------------------------------------------------------

	function automatic logic [7:0] rand_alnum();
		case ($urandom_range(0, 2))
			0:       return CH_ZERO + 8'($urandom_range(0, 9));
			1:       return CH_UC_A + 8'($urandom_range(0, 25));
			default: return CH_LC_A + 8'($urandom_range(0, 25));
		endcase
	endfunction

	function automatic logic [7:0] rand_op();
		case ($urandom_range(0, 3))
			0:       return CH_ADD;
			1:       return CH_SUB;
			2:       return CH_MUL;
			default: return CH_DIV;
		endcase
	endfunction

	// end flag on the last character only when asked
	task automatic queue_text(input logic [7:0] txt [$], input logic end_on_last);
		infix_item_t item;
		int i;
		for (i = 0; i < txt.size(); i++) begin
			item.ch = txt[i];
			item.eoe = end_on_last && (i == txt.size() - 1);
			infix_q = {infix_q, item};
		end
	endtask

	// well-formed formula with random operands, operators and nesting
	task automatic gen_formula();
		logic [7:0] txt [$];
		int n_terms, depth, i, j, len;
		n_terms = $urandom_range(1, 8);
		depth = 0;
		if ($urandom_range(0, 3) == 0)
			txt = {txt, CH_SUB};
		for (i = 0; i < n_terms; i++) begin
			while ($urandom_range(0, 3) == 0 && depth < 20) begin
				txt = {txt, CH_OPEN};
				depth++;
				if ($urandom_range(0, 2) == 0)
					txt = {txt, CH_SUB};
			end
			len = $urandom_range(1, 4);
			txt = {txt, rand_alnum()};
			for (j = 1; j < len; j++)
				txt = {txt, (($urandom_range(0, 4) == 0) ? CH_US : rand_alnum())};
			if ($urandom_range(0, 5) == 0)
				txt = {txt, CH_SPACE};
			while (depth > 0 && $urandom_range(0, 2) == 0) begin
				txt = {txt, CH_CLOSE};
				depth--;
			end
			if (i < n_terms - 1)
				txt = {txt, rand_op()};
		end
		// now and then leave opens for the flush
		while (depth > 0 && $urandom_range(0, 3) != 0) begin
			txt = {txt, CH_CLOSE};
			depth--;
		end
		queue_text(txt, $urandom_range(0, 7) != 0);
	endtask

	// nest close to or past the stack depth and end on an operator
	task automatic gen_deep_nest();
		logic [7:0] txt [$];
		int k, i;
		k = $urandom_range(12, 18);
		for (i = 0; i < k; i++) begin
			txt = {txt, CH_OPEN};
			if ($urandom_range(0, 3) == 0) begin
				txt = {txt, rand_alnum()};
				txt = {txt, rand_op()};
			end
		end
		txt = {txt, rand_alnum()};
		txt = {txt, rand_op()};
		queue_text(txt, 1'b1);
	endtask

	// token soup: stray closes, doubled operators, lone underscores
	task automatic gen_broken();
		logic [7:0] txt [$];
		int n, i;
		n = $urandom_range(1, 12);
		for (i = 0; i < n; i++) begin
			case ($urandom_range(0, 6))
				0, 1:    txt = {txt, rand_alnum()};
				2:       txt = {txt, rand_op()};
				3:       txt = {txt, CH_OPEN};
				4:       txt = {txt, CH_CLOSE};
				5:       txt = {txt, CH_US};
				default: txt = {txt, CH_SPACE};
			endcase
		end
		queue_text(txt, 1'($urandom_range(0, 1)));
	endtask

	// raw bytes over the full range, end flag anywhere
	task automatic gen_noise();
		infix_item_t item;
		int n, i;
		n = $urandom_range(1, 8);
		for (i = 0; i < n; i++) begin
			item.ch = 8'($urandom_range(0, 255));
			item.eoe = ($urandom_range(0, 3) == 0);
			infix_q = {infix_q, item};
		end
	endtask

	task automatic queue_string(input string s, input logic end_on_last);
		logic [7:0] txt [$];
		int i;
		for (i = 0; i < s.len(); i++)
			txt = {txt, s[i]};
		queue_text(txt, end_on_last);
	endtask

	// ------------------------------------------------------------------------
	// sequencing: fill the text queue, reset, wait for the drain, verdict
	// ------------------------------------------------------------------------
	initial begin
		int pick;
		clk = 1'b0;
		arst_n = 1'b0;
		expr.valid = 1'b0;
		expr.in_char = CH_NULL;
		expr.end_of_expression = 1'b0;
		postfix.ready = 1'b0;
		in_took = 1'b0;
		out_took = 1'b0;
		err_count = 0;
		in_count = 0;
		idle_cycles = 0;
		tx_wait = 0;
		tx_burst = 1'b0;
		rx_wait = 0;
		rx_burst = 1'b0;
		hold_left = 0;
		hold_done = 1'b0;
		stk_cnt = 0;
		in_word = 1'b0;
		unary_ok = 1'b1;

		// directed: leading minus, minus after an open, operand edges,
		// every operator, precedence, paren pop
		queue_string("-a_Z*(-9+0)/z", 1'b1);
		// close paren with nothing open
		queue_string(")", 1'b0);
		// bytes just outside the operand ranges, a high byte: all silent
		queue_string(":@[`{", 1'b0);
		queue_text('{8'hFF}, 1'b0);
		// open paren left on the stack, flushed at the end
		queue_string("(A-b", 1'b1);
		// lone underscore with end: marker item only
		queue_string("_", 1'b1);

		while (infix_q.size() < 470) begin
			pick = $urandom_range(0, 99);
			if (pick < 65)
				gen_formula();
			else if (pick < 75)
				gen_deep_nest();
			else if (pick < 88)
				gen_broken();
			else
				gen_noise();
		end

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (infix_q.size() != 0 || expr.valid || postfix_exp_q.size() != 0)
			@(posedge clk);
		// room for a stray late item to show up
		repeat (DRAIN_WAIT) @(posedge clk);
		if (postfix_exp_q.size() != 0)
			flag_error($sformatf("%0d postfix items never arrived", postfix_exp_q.size()));

		if (err_count == 0)
			$display("infix_to_postfix_converter regression: pass");
		else
			$display("infix_to_postfix_converter regression: fail");
		$finish;
	end

	// ------------------------------------------------------------------------
	// infix driver: changes on the falling edge, holds an item until taken
	// ------------------------------------------------------------------------
	always @(negedge clk) begin
		if (arst_n) begin
			tx_valid = expr.valid;
			if (expr.valid && in_took) begin
				tx_valid = 1'b0;
				tx_wait = pick_gap(tx_burst);
				// switch between gappy and back-to-back stretches
				if ($urandom_range(0, 49) == 0)
					tx_burst = !tx_burst;
			end
			if (!tx_valid && infix_q.size() != 0) begin
				if (tx_wait == 0) begin
					tx_item = infix_q.pop_front();
					expr.in_char <= tx_item.ch;
					expr.end_of_expression <= tx_item.eoe;
					tx_valid = 1'b1;
				end else begin
					tx_wait--;
				end
			end
			expr.valid <= tx_valid;
		end
	end

	// ------------------------------------------------------------------------
	// postfix receiver: random stalls plus one long hold that fills the block
	// ------------------------------------------------------------------------
	always @(negedge clk) begin
		if (arst_n) begin
			if (out_took) begin
				rx_wait = pick_gap(rx_burst);
				if ($urandom_range(0, 49) == 0)
					rx_burst = !rx_burst;
			end
			if (hold_left > 0) begin
				hold_left--;
				rx_ready = 1'b0;
			end else if (!hold_done && in_count >= HOLD_AT) begin
				// sender keeps offering while we sit on the output
				hold_left = HOLD_CYCLES - 1;
				hold_done = 1'b1;
				rx_ready = 1'b0;
			end else if (rx_wait > 0) begin
				rx_wait--;
				rx_ready = 1'b0;
			end else begin
				rx_ready = 1'b1;
			end
			postfix.ready <= rx_ready;
		end
	end

	// ------------------------------------------------------------------------
	// monitor: check the postfix side first, then predict from the infix side
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		in_took <= expr.valid && expr.ready;
		out_took <= postfix.valid && postfix.ready;
		if (arst_n) begin
			if (postfix.valid && postfix.ready) begin
				got_item.ch = postfix.out_char;
				got_item.ch_valid = postfix.char_valid;
				got_item.run_last = postfix.run_last;
				got_item.done = postfix.expr_done;
				got_item.err = postfix.error_code;
				if (postfix_exp_q.size() == 0) begin
					flag_error($sformatf("unexpected postfix item char %h", got_item.ch));
				end else begin
					exp_item = postfix_exp_q.pop_front();
					if (got_item.ch !== exp_item.ch)
						flag_error($sformatf("out_char %h, want %h", got_item.ch, exp_item.ch));
					if (got_item.ch_valid !== exp_item.ch_valid)
						flag_error($sformatf("char_valid %b, want %b",
							got_item.ch_valid, exp_item.ch_valid));
					if (got_item.run_last !== exp_item.run_last)
						flag_error($sformatf("run_last %b, want %b",
							got_item.run_last, exp_item.run_last));
					if (got_item.done !== exp_item.done)
						flag_error($sformatf("expr_done %b, want %b",
							got_item.done, exp_item.done));
					if (got_item.err !== exp_item.err)
						flag_error($sformatf("error_code %0d, want %0d",
							got_item.err, exp_item.err));
				end
			end
			if (expr.valid && expr.ready) begin
				predict_postfix(expr.in_char, expr.end_of_expression);
				in_count++;
			end
		end
	end

	// watchdog: give up when nothing moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((expr.valid && expr.ready) || (postfix.valid && postfix.ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("infix_to_postfix_converter regression: fail");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

endmodule
